// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the RC4 keystream block.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is high.
`define RC4KG_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rc4kg check failed");

// Check a property on every rising clock edge, reset included.
`define RC4KG_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("rc4kg check failed");

`endif

// ----- rtl/rc4kg_pkg.sv -----
// Shared constants and the sequencer state type of the RC4 keystream generator.
// No dependencies; imported by the top level and by the checker.
package rc4kg_pkg;

   localparam int PERM_SIZE     = 256;
   localparam int MAX_KEY_BYTES = 256;
   localparam int BYTE_W        = 8;
   localparam int IDX_W         = $clog2(PERM_SIZE);
   localparam int LEN_W         = 9;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PERM_SIZE - 1);

   typedef enum logic [10:0] {
      ST_FILL    = 11'b000_0000_0001,
      ST_IDLE    = 11'b000_0000_0010,
      ST_KS_INIT = 11'b000_0000_0100,
      ST_KS_RD_I = 11'b000_0000_1000,
      ST_KS_RD_J = 11'b000_0001_0000,
      ST_KS_WR_I = 11'b000_0010_0000,
      ST_KS_WR_J = 11'b000_0100_0000,
      ST_PG_RD_J = 11'b000_1000_0000,
      ST_PG_WR_I = 11'b001_0000_0000,
      ST_PG_WR_J = 11'b010_0000_0000,
      ST_EMPTY   = 11'b100_0000_0000
   } state_type;

endpackage

// ----- rtl/rc4kg_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; read data holds while the read enable is low.
module rc4kg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rc4_keystream_generator_unit.sv -----
// RC4 keystream generator: key load, 256-step key schedule, one PRGA step per item.
// Depends on rc4kg_pkg and two rc4kg_ram instances (permutation and key bytes).
// Key byte: stored in idle; the last one starts an identity fill, then the key schedule.
// Keystream byte: read S[i], S[j]; write S[i], read S[t]; write S[j] and register the byte;
// the permutation RAM has one read and one write port; no new item is taken until idle.
// Reset: synchronous, active high; an identity fill of all 256 permutation entries follows.
module rc4_keystream_generator_unit
   import rc4kg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] key_byte
   input  logic              req_tlast,   // key_last
   input  logic              req_tuser,   // [0] func: 0 load key byte, 1 generate
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata    // [7:0] keystream_byte
);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;      // schedule / fill position n
   logic [IDX_W-1:0]    kidx_ff, kidx_in;    // key position n mod len
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                keyed_ff, keyed_in;
   logic [BYTE_W-1:0]   si_ff, si_in;        // S[i] (or S[n]) held across the swap
   logic                fwd_hit_ff, fwd_hit_in;
   logic [BYTE_W-1:0]   fwd_val_ff, fwd_val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                p_we, p_re;
   logic [IDX_W-1:0]    p_waddr, p_raddr;
   logic [BYTE_W-1:0]   p_wdata, p_rdata;
   logic                k_we, k_re;
   logic [IDX_W-1:0]    k_waddr, k_raddr;
   logic [BYTE_W-1:0]   k_rdata;

   logic                req_accept;
   logic                slot_free;
   logic [IDX_W-1:0]    j_sum;
   logic [IDX_W-1:0]    t_idx;

   // Take items only between operations; the output register decouples the result side.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kidx_in      = kidx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      len_in       = len_ff;
      keyed_in     = keyed_ff;
      si_in        = si_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_val_in   = fwd_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      p_we    = 1'b0;
      p_waddr = '0;
      p_wdata = '0;
      p_re    = 1'b0;
      p_raddr = '0;
      k_we    = 1'b0;
      k_waddr = len_ff[IDX_W-1:0];
      k_re    = 1'b0;
      k_raddr = kidx_ff;
      j_sum   = '0;
      t_idx   = '0;

      case (state_ff)
         // Write the identity permutation, one entry a cycle.
         ST_FILL, ST_KS_INIT: begin
            p_we    = 1'b1;
            p_waddr = cnt_ff;
            p_wdata = cnt_ff;
            cnt_in  = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_LAST) begin
               state_in = (state_ff == ST_FILL) ? ST_IDLE : ST_KS_RD_I;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               if (!req_tuser) begin
                  // Key byte: drop it once the key store is full.
                  keyed_in = 1'b0;
                  if (len_ff < LEN_W'(MAX_KEY_BYTES)) begin
                     k_we   = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                  end
                  if (req_tlast) begin
                     state_in = ST_KS_INIT;
                     cnt_in   = '0;
                     kidx_in  = '0;
                     j_in     = '0;
                  end
               end else if (keyed_ff) begin
                  // Advance i and start the read of S[i] right away.
                  i_in     = i_ff + IDX_W'(1);
                  p_re     = 1'b1;
                  p_raddr  = i_ff + IDX_W'(1);
                  state_in = ST_PG_RD_J;
               end else begin
                  state_in = ST_EMPTY;
               end
            end
         end

         ST_KS_RD_I: begin
            p_re     = 1'b1;
            p_raddr  = cnt_ff;
            k_re     = 1'b1;
            k_raddr  = kidx_ff;
            state_in = ST_KS_RD_J;
         end

         ST_KS_RD_J: begin
            j_sum    = j_ff + p_rdata + k_rdata;
            j_in     = j_sum;
            si_in    = p_rdata;
            p_re     = 1'b1;
            p_raddr  = j_sum;
            state_in = ST_KS_WR_I;
         end

         ST_KS_WR_I: begin
            p_we     = 1'b1;
            p_waddr  = cnt_ff;
            p_wdata  = p_rdata;
            state_in = ST_KS_WR_J;
         end

         ST_KS_WR_J: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            cnt_in  = cnt_ff + IDX_W'(1);
            // Cycle the key position over the stored length.
            if ((LEN_W'(kidx_ff) + LEN_W'(1)) >= len_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + IDX_W'(1);
            end
            if (cnt_ff == IDX_LAST) begin
               i_in     = '0;
               j_in     = '0;
               len_in   = '0;
               keyed_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_RD_I;
            end
         end

         ST_PG_RD_J: begin
            j_sum    = j_ff + p_rdata;
            j_in     = j_sum;
            si_in    = p_rdata;
            p_re     = 1'b1;
            p_raddr  = j_sum;
            state_in = ST_PG_WR_I;
         end

         ST_PG_WR_I: begin
            // Write S[i] = S[j] and read S[t] in the same cycle; forward the two
            // entries of the swap, since the RAM does not see them yet.
            p_we    = 1'b1;
            p_waddr = i_ff;
            p_wdata = p_rdata;
            t_idx   = si_ff + p_rdata;
            p_re    = 1'b1;
            p_raddr = t_idx;
            if (t_idx == i_ff) begin
               fwd_hit_in = 1'b1;
               fwd_val_in = p_rdata;
            end else if (t_idx == j_ff) begin
               fwd_hit_in = 1'b1;
               fwd_val_in = si_ff;
            end else begin
               fwd_hit_in = 1'b0;
               fwd_val_in = p_rdata;
            end
            state_in = ST_PG_WR_J;
         end

         ST_PG_WR_J: begin
            // Hold here while the previous result waits; the rewrite is harmless.
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fwd_hit_ff ? fwd_val_ff : p_rdata;
               state_in     = ST_IDLE;
            end
         end

         ST_EMPTY: begin
            // Generate without a key: return zero, touch no state.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         kidx_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         len_ff       <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         kidx_ff      <= kidx_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         len_ff       <= len_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_val_ff  <= fwd_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Permutation S.
   rc4kg_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_SIZE)) u_perm_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (p_re),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   // Key bytes of the key being loaded.
   rc4kg_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_BYTES)) u_key_ram (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_waddr),
      .wr_data (req_tdata),
      .rd_en   (k_re),
      .rd_addr (k_raddr),
      .rd_data (k_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/rc4kg_checker.sv -----
// Port-level checks for the RC4 keystream generator, bound to its top level.
// Depends on rc4kg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rc4kg_checker
   import rc4kg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              req_tlast,
   input logic              req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [BYTE_W-1:0] rsp_tdata
);

   // A stalled result transaction stays offered and unchanged.
   `RC4KG_ASSERT(a_rsp_hold_valid, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `RC4KG_ASSERT(a_rsp_hold_data, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))

   // The identity fill after reset keeps the input closed.
   `RC4KG_ASSERT_ALWAYS(a_fill_after_reset, reset |=> !req_tready)

   // A generate or a final key byte starts multi-cycle work: no back-to-back accept.
   `RC4KG_ASSERT(a_busy_after_work,
      req_tvalid && req_tready && (req_tuser || req_tlast) |=> !req_tready)

endmodule

bind rc4_keystream_generator_unit rc4kg_checker u_rc4kg_checker (.*);
